>>> design/bmf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// bmf_pkg: sizes, shared types and helper functions of the box mean filter
// no dependencies; imported by every module of the block

package bmf_pkg;

    localparam int MAX_KSIZE    = 9;
    localparam int MAX_WIDTH    = 2048;
    localparam int MAX_CHANNELS = 4;

    localparam int KMAX      = (MAX_KSIZE % 2 == 0) ? MAX_KSIZE - 1 : MAX_KSIZE;
    localparam int LINE_ROWS = MAX_KSIZE - 1;
    localparam int LW        = 16 * LINE_ROWS;
    localparam int DEPTH     = MAX_WIDTH * MAX_CHANNELS;
    localparam int ADDRW     = $clog2(DEPTH);

    localparam int KW   = $clog2(MAX_KSIZE + 1);
    localparam int COLW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int WW   = $clog2(MAX_WIDTH + 1);
    localparam int CHW  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int NCHW = $clog2(MAX_CHANNELS + 1);

    localparam int CSW  = 17 + $clog2(MAX_KSIZE);
    localparam int WSW  = 17 + $clog2(MAX_KSIZE * MAX_KSIZE);
    localparam int MAGW = WSW - 1;
    localparam int DW   = $clog2(KMAX * KMAX + 1);

    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    typedef enum logic [1:0] {
        ET_U8  = 2'd0,
        ET_S8  = 2'd1,
        ET_U16 = 2'd2,
        ET_S16 = 2'd3
    } etype_t;

    typedef struct packed {
        etype_t            etype;
        logic [KW-1:0]     k;
        logic [WW-1:0]     w;
        logic [NCHW-1:0]   nch;
    } cfg_t;

    typedef struct packed {
        logic [15:0]       raw;
        logic [ADDRW-1:0]  addr;
        logic [CHW-1:0]    ch;
        logic              emit;
        logic              rlast;
        logic              fend;
    } item_t;

    function automatic logic signed [16:0] decode(input logic [15:0] raw, input etype_t et);
        case (et)
            ET_U8:   return {9'b0, raw[7:0]};
            ET_S8:   return {{9{raw[7]}}, raw[7:0]};
            ET_U16:  return {1'b0, raw};
            default: return {raw[15], raw};
        endcase
    endfunction

    // floor((2^32 - 1) / k^2)
    function automatic logic [31:0] recip(input logic [KW-1:0] k);
        case (32'(k))
            1:       return 32'd4294967295;
            3:       return 32'd477218588;
            5:       return 32'd171798691;
            7:       return 32'd87652393;
            9:       return 32'd53024287;
            11:      return 32'd35495597;
            13:      return 32'd25414007;
            15:      return 32'd19088743;
            17:      return 32'd14861478;
            19:      return 32'd11897416;
            21:      return 32'd9739154;
            23:      return 32'd8119030;
            25:      return 32'd6871947;
            27:      return 32'd5891587;
            29:      return 32'd5106976;
            31:      return 32'd4469268;
            default: return 32'd4294967295;
        endcase
    endfunction

endpackage

`default_nettype wire

>>> design/box_mean_filter.sv
`timescale 1ns / 1ps
`default_nettype none
// box_mean_filter: top level, configuration registers and channel wiring
// depends on bmf_pkg, bmf_front, bmf_queue, bmf_back

// k-by-k box mean over a bordered image streamed in raster order with
// interleaved channels. One sample is taken every clock while the request
// queue is not full. A sample's result passes the seven-stage back pipeline
// (line store read, column sum, window, sum, multiply, quotient, back multiply)
// and the output register, which also applies the quotient correction. The
// line store is one 8192 x 128 memory, one read and one write a cycle, with
// no clearing pass after reset. Write configuration only while the stream is
// idle.

module box_mean_filter import bmf_pkg::*; (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          cfg_we,
    input  wire logic [1:0]    cfg_addr,
    input  wire logic [11:0]   cfg_wdata,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire logic [23:0]   s_tdata,   // sample[16:0], zero pad
    input  wire logic          s_tuser,   // frame_start
    input  wire logic          s_tlast,   // frame_end
    output logic               m_tvalid,
    input  wire logic          m_tready,
    output logic [23:0]        m_tdata,   // mean[16:0], channel_index[18:17], zero pad
    output logic               m_tuser,   // row_last
    output logic               m_tlast    // frame_last
);

    typedef enum logic [1:0] {
        REG_ELEMENT_TYPE  = 2'd0,
        REG_KERNEL_SIZE   = 2'd1,
        REG_LINE_WIDTH    = 2'd2,
        REG_CHANNEL_COUNT = 2'd3
    } reg_idx_t;

    logic [1:0]  etype_reg;
    logic [3:0]  ksize_reg;
    logic [11:0] width_reg;
    logic [2:0]  nch_reg;
    cfg_t        cfg;
    int          kk, ww, cc;

    item_t       push_item, head;
    logic        q_push, q_pop, q_empty, q_full;
    logic [16:0] mean;
    logic [1:0]  ch;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            etype_reg <= 2'd0;
            ksize_reg <= 4'd3;
            width_reg <= 12'd640;
            nch_reg   <= 3'd1;
        end else if (cfg_we) begin
            case (reg_idx_t'(cfg_addr))
                REG_ELEMENT_TYPE:  etype_reg <= cfg_wdata[1:0];
                REG_KERNEL_SIZE:   ksize_reg <= cfg_wdata[3:0];
                REG_LINE_WIDTH:    width_reg <= cfg_wdata[11:0];
                REG_CHANNEL_COUNT: nch_reg   <= cfg_wdata[2:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        kk = 32'(ksize_reg | 4'd1);
        if (kk > KMAX) begin
            kk = KMAX;
        end
        ww = 32'(width_reg);
        if (ww == 0) begin
            ww = 1;
        end else if (ww > MAX_WIDTH) begin
            ww = MAX_WIDTH;
        end
        cc = 32'(nch_reg);
        if (cc == 0) begin
            cc = 1;
        end else if (cc > MAX_CHANNELS) begin
            cc = MAX_CHANNELS;
        end
        cfg.etype = etype_t'(etype_reg);
        cfg.k     = KW'(kk);
        cfg.w     = WW'(ww);
        cfg.nch   = NCHW'(cc);
    end

    bmf_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .sample   (s_tdata[16:0]),
        .fstart   (s_tuser),
        .fend     (s_tlast),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_item   (push_item)
    );

    bmf_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (push_item),
        .pop       (q_pop),
        .head      (head),
        .empty     (q_empty),
        .full      (q_full)
    );

    bmf_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .head      (head),
        .q_empty   (q_empty),
        .q_pop     (q_pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_mean  (mean),
        .out_ch    (ch),
        .out_rlast (m_tuser),
        .out_fend  (m_tlast)
    );

    assign m_tdata = {5'b0, ch, mean};

endmodule

`default_nettype wire

>>> design/bmf_front.sv
`timescale 1ns / 1ps
`default_nettype none
// bmf_front: position counters, classifies each request (emit, row end, store address)
// depends on bmf_pkg

module bmf_front import bmf_pkg::*; (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire cfg_t          cfg,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire logic [16:0]   sample,
    input  wire logic          fstart,
    input  wire logic          fend,
    input  wire logic          q_full,
    output logic               q_push,
    output item_t              q_item
);

    logic [COLW-1:0] col_reg, col_next, col_c;
    logic [KW-1:0]   rows_reg, rows_next, rows_c;
    logic [CHW-1:0]  ch_reg, ch_next, ch_c;
    logic [KW-1:0]   km1;

    assign in_ready = !q_full;
    assign q_push   = in_valid && !q_full;
    assign km1      = cfg.k - 1'b1;

    always_comb begin
        col_c  = fstart ? '0 : col_reg;
        rows_c = fstart ? '0 : rows_reg;
        ch_c   = fstart ? '0 : ch_reg;
        if (32'(col_c) >= 32'(cfg.w)) begin
            col_c = '0;
        end
        if (32'(ch_c) >= 32'(cfg.nch)) begin
            ch_c = '0;
        end
        if (rows_c > km1) begin
            rows_c = km1;
        end

        q_item.raw   = sample[15:0];
        q_item.addr  = ADDRW'(32'(col_c) * MAX_CHANNELS + 32'(ch_c));
        q_item.ch    = ch_c;
        q_item.emit  = (rows_c >= km1) && (32'(col_c) >= 32'(km1));
        q_item.rlast = (32'(col_c) == 32'(cfg.w) - 1) && (32'(ch_c) == 32'(cfg.nch) - 1);
        q_item.fend  = fend;

        col_next  = col_c;
        rows_next = rows_c;
        ch_next   = ch_c + 1'b1;
        if (32'(ch_c) + 1 >= 32'(cfg.nch)) begin
            ch_next  = '0;
            col_next = col_c + 1'b1;
            if (32'(col_c) + 1 >= 32'(cfg.w)) begin
                col_next = '0;
                if (rows_c < km1) begin
                    rows_next = rows_c + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg  <= '0;
            rows_reg <= '0;
            ch_reg   <= '0;
        end else if (q_push) begin
            col_reg  <= col_next;
            rows_reg <= rows_next;
            ch_reg   <= ch_next;
        end
    end

endmodule

`default_nettype wire

>>> design/bmf_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// bmf_queue: short request queue between front and back
// depends on bmf_pkg

module bmf_queue import bmf_pkg::*; (
    input  wire logic   aclk,
    input  wire logic   aresetn,
    input  wire logic   push,
    input  wire item_t  push_item,
    input  wire logic   pop,
    output item_t       head,
    output logic        empty,
    output logic        full
);

    item_t          slot_reg [QDEPTH];
    logic [QAW-1:0] wr_reg, rd_reg;
    logic [QAW:0]   cnt_reg;

    assign head  = slot_reg[rd_reg];
    assign empty = (cnt_reg == '0);
    assign full  = (32'(cnt_reg) == QDEPTH);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) begin
                wr_reg <= (32'(wr_reg) == QDEPTH - 1) ? '0 : wr_reg + 1'b1;
            end
            if (pop) begin
                rd_reg <= (32'(rd_reg) == QDEPTH - 1) ? '0 : rd_reg + 1'b1;
            end
            if (push && !pop) begin
                cnt_reg <= cnt_reg + 1'b1;
            end else if (pop && !push) begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

>>> design/bmf_back.sv
`timescale 1ns / 1ps
`default_nettype none
// bmf_back: line store, column sums, per-channel window, divide by area, output register
// depends on bmf_pkg

module bmf_back import bmf_pkg::*; (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire cfg_t          cfg,
    input  wire item_t         head,
    input  wire logic          q_empty,
    output logic               q_pop,
    output logic               out_valid,
    input  wire logic          out_ready,
    output logic [16:0]        out_mean,
    output logic [1:0]         out_ch,
    output logic               out_rlast,
    output logic               out_fend
);

    typedef struct packed {
        logic [CHW-1:0] ch;
        logic           emit;
        logic           rlast;
        logic           fend;
    } meta_t;

    logic adv;

    // line store
    logic [LW-1:0]    mem [DEPTH];
    logic [LW-1:0]    rd_reg;
    logic [LW-1:0]    lw_data_reg;
    logic [ADDRW-1:0] lw_addr_reg;
    logic             lw_valid_reg;

    // stage 1
    logic             v1_reg;
    item_t            i1_reg;
    logic [LW-1:0]    word, nword;
    logic [LW+15:0]   word_ext;
    logic signed [CSW-1:0] colsum;

    // stage 2
    logic             v2_reg;
    meta_t            m2_reg;
    logic signed [CSW-1:0] cs2_reg;
    logic signed [CSW-1:0] win_reg [MAX_CHANNELS][MAX_KSIZE];
    logic signed [CSW-1:0] row [MAX_KSIZE];
    logic signed [CSW-1:0] nrow [MAX_KSIZE];

    // stage 3
    logic             v3_reg;
    meta_t            m3_reg;
    logic signed [CSW-1:0] snap_reg [MAX_KSIZE];
    logic signed [WSW-1:0] wsum;

    // stages 4 to 7
    logic             v4_reg, v5_reg, v6_reg, v7_reg;
    meta_t            m4_reg, m5_reg, m6_reg, m7_reg;
    logic             n4_reg, n5_reg, n6_reg, n7_reg;
    logic [MAGW-1:0]  mag4_reg, mag5_reg, mag6_reg, mag7_reg;
    logic [MAGW+31:0] prod5_reg;
    logic [MAGW-1:0]  q6_reg, q7_reg;
    logic [MAGW-1:0]  qd7_reg;
    logic [DW-1:0]    dvs;
    logic [MAGW-1:0]  rem7, qf7;
    logic [16:0]      mean7;

    // output
    logic             ov_reg;
    logic [16:0]      omean_reg;
    logic [1:0]       och_reg;
    logic             orl_reg, ofe_reg;

    assign adv   = !ov_reg || out_ready;
    assign q_pop = adv && !q_empty;
    assign dvs   = DW'(32'(cfg.k) * 32'(cfg.k));

    assign out_valid = ov_reg;
    assign out_mean  = omean_reg;
    assign out_ch    = och_reg;
    assign out_rlast = orl_reg;
    assign out_fend  = ofe_reg;

    // column sum and shifted store word
    always_comb begin
        word     = (lw_valid_reg && lw_addr_reg == i1_reg.addr) ? lw_data_reg : rd_reg;
        word_ext = {16'b0, word};
        colsum   = CSW'(decode(i1_reg.raw, cfg.etype));
        for (int r = 0; r < LINE_ROWS; r++) begin
            if (r + 1 < 32'(cfg.k)) begin
                colsum = colsum + CSW'(decode(word[r*16 +: 16], cfg.etype));
            end
        end
        nword = word;
        for (int r = 0; r < LINE_ROWS; r++) begin
            if (r + 2 < 32'(cfg.k)) begin
                nword[r*16 +: 16] = word_ext[(r+1)*16 +: 16];
            end else if (r + 2 == 32'(cfg.k)) begin
                nword[r*16 +: 16] = i1_reg.raw;
            end
        end
    end

    // window shift for the channel of stage 2
    always_comb begin
        for (int j = 0; j < MAX_KSIZE; j++) begin
            row[j] = win_reg[m2_reg.ch][j];
        end
        for (int j = 0; j < MAX_KSIZE; j++) begin
            if (j + 1 < 32'(cfg.k)) begin
                nrow[j] = row[(j + 1 < MAX_KSIZE) ? j + 1 : j];
            end else if (j + 1 == 32'(cfg.k)) begin
                nrow[j] = cs2_reg;
            end else begin
                nrow[j] = row[j];
            end
        end
    end

    always_comb begin
        wsum = '0;
        for (int j = 0; j < MAX_KSIZE; j++) begin
            if (j < 32'(cfg.k)) begin
                wsum = wsum + WSW'(snap_reg[j]);
            end
        end
    end

    always_comb begin
        rem7  = mag7_reg - qd7_reg;
        qf7   = (32'(rem7) >= 32'(dvs)) ? q7_reg + 1'b1 : q7_reg;
        mean7 = n7_reg ? 17'(-qf7) : 17'(qf7);
    end

    always_ff @(posedge aclk) begin
        if (adv && q_pop) begin
            rd_reg <= mem[head.addr];
        end
        if (adv && v1_reg) begin
            mem[i1_reg.addr] <= nword;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg       <= 1'b0;
            v2_reg       <= 1'b0;
            v3_reg       <= 1'b0;
            v4_reg       <= 1'b0;
            v5_reg       <= 1'b0;
            v6_reg       <= 1'b0;
            v7_reg       <= 1'b0;
            ov_reg       <= 1'b0;
            lw_valid_reg <= 1'b0;
            for (int c = 0; c < MAX_CHANNELS; c++) begin
                for (int j = 0; j < MAX_KSIZE; j++) begin
                    win_reg[c][j] <= '0;
                end
            end
        end else if (adv) begin
            v1_reg <= q_pop;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
            v7_reg <= v6_reg;
            ov_reg <= v7_reg && m7_reg.emit;
            if (v1_reg) begin
                lw_valid_reg <= 1'b1;
            end
            if (v2_reg) begin
                for (int j = 0; j < MAX_KSIZE; j++) begin
                    win_reg[m2_reg.ch][j] <= nrow[j];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            i1_reg <= head;
            if (v1_reg) begin
                lw_addr_reg <= i1_reg.addr;
                lw_data_reg <= nword;
            end
            m2_reg  <= '{ch: i1_reg.ch, emit: i1_reg.emit, rlast: i1_reg.rlast,
                         fend: i1_reg.fend};
            cs2_reg <= colsum;
            m3_reg  <= m2_reg;
            for (int j = 0; j < MAX_KSIZE; j++) begin
                snap_reg[j] <= nrow[j];
            end
            m4_reg    <= m3_reg;
            n4_reg    <= wsum[WSW-1];
            mag4_reg  <= wsum[WSW-1] ? MAGW'(-wsum) : MAGW'(wsum);
            m5_reg    <= m4_reg;
            n5_reg    <= n4_reg;
            mag5_reg  <= mag4_reg;
            prod5_reg <= (MAGW+32)'(mag4_reg) * (MAGW+32)'(recip(cfg.k));
            m6_reg    <= m5_reg;
            n6_reg    <= n5_reg;
            mag6_reg  <= mag5_reg;
            q6_reg    <= prod5_reg[32 +: MAGW];
            m7_reg    <= m6_reg;
            n7_reg    <= n6_reg;
            mag7_reg  <= mag6_reg;
            q7_reg    <= q6_reg;
            qd7_reg   <= MAGW'(q6_reg * MAGW'(dvs));
            omean_reg <= mean7;
            och_reg   <= 2'(m7_reg.ch);
            orl_reg   <= m7_reg.rlast;
            ofe_reg   <= m7_reg.fend;
        end
    end

    a_stall_freezes: assert property (@(posedge aclk) disable iff (!aresetn)
        !adv |=> $stable(v1_reg) && $stable(v7_reg) && $stable(omean_reg))
        else $error("pipeline moved during output stall");

    a_rem_range: assert property (@(posedge aclk) disable iff (!aresetn)
        v7_reg && m7_reg.emit |-> (32'(rem7) < 2 * 32'(dvs)))
        else $error("quotient estimate off by more than one");

    a_out_from_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(ov_reg) |-> $past(v7_reg && m7_reg.emit))
        else $error("result without a full window");

endmodule

`default_nettype wire
